[hw/rtl/pfm_pkg.sv]
// Package for the PCM frame mixer: config struct, shared-unit request and
// response structs, state enums and arithmetic constants.
// No dependencies.
`default_nettype none

package pfm_pkg;

    localparam int unsigned ADDR_W = 5;

    localparam logic [15:0] GAIN_FULL    = 16'd32767;
    localparam logic [15:0] PERCENT_FULL = 16'd100;
    localparam logic [6:0]  VOL_FULL     = 7'd100;
    localparam logic [15:0] FADE_MS      = 16'd45;
    localparam logic [15:0] MS_PER_SEC   = 16'd1000;
    localparam logic [11:0] FADE_MIN     = 12'd32;

    typedef enum logic [2:0] {
        REG_SIXTEEN_BIT = 3'd0,
        REG_STEREO      = 3'd1,
        REG_VOLUME      = 3'd2,
        REG_SAMPLE_RATE = 3'd3,
        REG_DATA_BYTES  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic        sixteen_bit;
        logic        stereo;
        logic [6:0]  volume_percent;
        logic [15:0] sample_rate;
        logic [31:0] data_bytes;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [16:0] a_mag;
        logic        a_neg;
        logic [15:0] mult;
        logic [15:0] divisor;
    } t_md_req;

    typedef struct packed {
        logic               done;
        logic signed [16:0] quotient;
    } t_md_rsp;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } t_md_state;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAIN,
        ST_FADE,
        ST_MIX,
        ST_FIN,
        ST_FOUT,
        ST_WAIT,
        ST_EMIT
    } t_seq_state;

endpackage

`default_nettype wire

[hw/rtl/pfm_in_if.sv]
// Input channel of the PCM frame mixer: valid/ready plus one raw frame.
// No dependencies.
`default_nettype none

interface pfm_in_if;
    logic        valid;
    logic        ready;
    logic        first_frame;
    logic [15:0] left_raw;
    logic [15:0] right_raw;

    modport source (output valid, output first_frame, output left_raw,
                    output right_raw, input ready);
    modport sink   (input valid, input first_frame, input left_raw,
                    input right_raw, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfm_out_if.sv]
// Output channel of the PCM frame mixer: valid/ready plus one mono sample.
// No dependencies.
`default_nettype none

interface pfm_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfm_cfg_regs.sv]
// APB-style configuration registers of the PCM frame mixer.
// Depends on pfm_pkg.
`default_nettype none

module pfm_cfg_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output pfm_pkg::t_cfg                   o_cfg,
    output logic                            o_cfg_wr
);
    import pfm_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign pready   = 1'b1;
    assign idx      = paddr[ADDR_W-1:2];
    assign wr_en    = psel & penable & pwrite & pready;
    assign o_cfg_wr = wr_en;
    assign o_cfg    = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (idx)
                REG_SIXTEEN_BIT: n_cfg.sixteen_bit    = pwdata[0];
                REG_STEREO:      n_cfg.stereo         = pwdata[0];
                REG_VOLUME:      n_cfg.volume_percent = pwdata[6:0];
                REG_SAMPLE_RATE: n_cfg.sample_rate    = pwdata[15:0];
                REG_DATA_BYTES:  n_cfg.data_bytes     = pwdata;
                default:         n_cfg                = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SIXTEEN_BIT: prdata = {31'd0, r_cfg.sixteen_bit};
            REG_STEREO:      prdata = {31'd0, r_cfg.stereo};
            REG_VOLUME:      prdata = {25'd0, r_cfg.volume_percent};
            REG_SAMPLE_RATE: prdata = {16'd0, r_cfg.sample_rate};
            REG_DATA_BYTES:  prdata = r_cfg.data_bytes;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sixteen_bit    <= 1'b1;
            r_cfg.stereo         <= 1'b0;
            r_cfg.volume_percent <= VOL_FULL;
            r_cfg.sample_rate    <= 16'd44100;
            r_cfg.data_bytes     <= 32'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/pfm_muldiv.sv]
// Shared multiply-divide unit: |a| * m / d truncated toward zero, sign applied,
// a registered multiply step, then two restoring divide steps per cycle.
// Depends on pfm_pkg.
`default_nettype none

module pfm_muldiv (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pfm_pkg::t_md_req i_req,
    output pfm_pkg::t_md_rsp      o_rsp
);
    import pfm_pkg::*;

    t_md_state   r_state, n_state;
    logic [16:0] r_a, n_a;
    logic        r_neg, n_neg;
    logic [15:0] r_m, n_m;
    logic [15:0] r_d, n_d;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_quo, n_quo;
    logic [2:0]  r_cnt, n_cnt;
    logic [32:0] prod;
    logic [16:0] step1;
    logic [16:0] step2;
    logic [16:0] quo_ext;

    function automatic logic [16:0] div_step(input logic [15:0] rem,
                                             input logic        bit_in,
                                             input logic [15:0] d);
        logic [16:0] t;
        logic [16:0] diff;
        t    = {rem, bit_in};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[15:0]};
        end else begin
            return {1'b0, t[15:0]};
        end
    endfunction

    assign prod  = {16'd0, r_a} * {17'd0, r_m};
    assign step1 = div_step(r_rem, r_quo[15], r_d);
    assign step2 = div_step(step1[15:0], r_quo[14], r_d);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: if (i_req.start) n_state = MD_MUL;
            MD_MUL:  n_state = MD_DIV;
            MD_DIV:  if (r_cnt == 3'd0) n_state = MD_DONE;
            MD_DONE: n_state = MD_IDLE;
            default: n_state = MD_IDLE;
        endcase
    end

    always_comb begin
        n_a   = r_a;
        n_neg = r_neg;
        n_m   = r_m;
        n_d   = r_d;
        n_rem = r_rem;
        n_quo = r_quo;
        n_cnt = r_cnt;
        unique case (r_state)
            MD_IDLE: begin
                if (i_req.start) begin
                    n_a   = i_req.a_mag;
                    n_neg = i_req.a_neg;
                    n_m   = i_req.mult;
                    n_d   = i_req.divisor;
                end
            end
            MD_MUL: begin
                n_rem = prod[31:16];
                n_quo = prod[15:0];
                n_cnt = 3'd7;
            end
            MD_DIV: begin
                n_rem = step2[15:0];
                n_quo = {r_quo[13:0], step1[16], step2[16]};
                n_cnt = r_cnt - 3'd1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    assign quo_ext        = {1'b0, r_quo};
    assign o_rsp.done     = (r_state == MD_DONE);
    assign o_rsp.quotient = r_neg ? -$signed(quo_ext) : $signed(quo_ext);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_neg <= n_neg;
        r_m   <= n_m;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

endmodule

`default_nettype wire

[hw/rtl/pcm_frame_mix_gain_fade.sv]
// Sequencing: the gain and fade length are recomputed on the shared multiply-divide unit
//   on the first request after reset or a config write, before the frame is mixed.
// Requests: one at a time; the input is ready only while idle. Each frame needs up to three
//   multiply-divide ops (gain, fade-in, fade-out), five if gain and fade are recomputed.
// Reset: synchronous active-low; clears frame count, sequencer and output valid,
//   config registers return to their defaults.
`default_nettype none

module pcm_frame_mix_gain_fade (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    pfm_in_if.sink                          i_in,
    pfm_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfm_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);
    import pfm_pkg::*;

    t_cfg               cfg;
    logic               cfg_wr;
    t_md_req            md_req;
    t_md_rsp            md_rsp;

    t_seq_state         r_state, n_state;
    t_seq_state         r_ret, n_ret;
    logic [31:0]        r_frame_count, n_frame_count;
    logic [31:0]        r_pos, n_pos;
    logic signed [16:0] r_s, n_s;
    logic [14:0]        r_gain, n_gain;
    logic [11:0]        r_fade, n_fade;
    logic               r_derived_ok, n_derived_ok;
    logic               r_ovalid, n_ovalid;
    logic signed [15:0] r_out, n_out;

    logic               in_acc;
    logic               out_acc;
    logic signed [15:0] left_s;
    logic signed [15:0] right_s;
    logic signed [16:0] sum;
    logic signed [16:0] sum_adj;
    logic [31:0]        total;
    logic [31:0]        fade_ext;
    logic [31:0]        tail;
    logic               fin_hit;
    logic               fout_hit;
    logic [16:0]        s_bits;
    logic               s_neg;
    logic [16:0]        s_mag;
    logic [6:0]         vol_sat;
    logic [11:0]        fade_q;
    logic signed [15:0] clamped;

    pfm_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    pfm_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_rsp   (md_rsp)
    );

    assign in_acc  = i_in.valid & i_in.ready;
    assign out_acc = o_out.valid & o_out.ready;

    assign left_s  = cfg.sixteen_bit ? $signed(i_in.left_raw)
                                     : $signed({~i_in.left_raw[7], i_in.left_raw[6:0], 8'h00});
    assign right_s = !cfg.stereo     ? left_s
                   : cfg.sixteen_bit ? $signed(i_in.right_raw)
                                     : $signed({~i_in.right_raw[7], i_in.right_raw[6:0], 8'h00});
    assign sum     = 17'(left_s) + 17'(right_s);
    assign sum_adj = sum + $signed({16'd0, sum[16]});

    always_comb begin
        unique case ({cfg.sixteen_bit, cfg.stereo})
            2'b00:   total = cfg.data_bytes;
            2'b11:   total = {2'b00, cfg.data_bytes[31:2]};
            default: total = {1'b0, cfg.data_bytes[31:1]};
        endcase
    end

    assign fade_ext = {20'd0, r_fade};
    assign tail     = total - r_pos;
    assign fin_hit  = r_pos < fade_ext;
    assign fout_hit = (total > r_pos) && (tail < fade_ext);
    assign s_bits   = r_s;
    assign s_neg    = r_s[16];
    assign s_mag    = s_neg ? (~s_bits + 17'd1) : s_bits;
    assign vol_sat  = (cfg.volume_percent > VOL_FULL) ? VOL_FULL : cfg.volume_percent;
    assign fade_q   = md_rsp.quotient[11:0];

    always_comb begin
        if (r_s > 17'sd32767) begin
            clamped = 16'sh7fff;
        end else if (r_s < -17'sd32768) begin
            clamped = 16'sh8000;
        end else begin
            clamped = r_s[15:0];
        end
    end

    assign i_in.ready       = (r_state == ST_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.sample_out = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (in_acc) n_state = r_derived_ok ? ST_MIX : ST_GAIN;
            ST_GAIN: n_state = ST_WAIT;
            ST_FADE: n_state = ST_WAIT;
            ST_MIX:  n_state = ST_WAIT;
            ST_FIN:  n_state = fin_hit ? ST_WAIT : ST_FOUT;
            ST_FOUT: n_state = fout_hit ? ST_WAIT : ST_EMIT;
            ST_WAIT: if (md_rsp.done) n_state = r_ret;
            ST_EMIT: if (!r_ovalid || o_out.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_ret         = r_ret;
        n_frame_count = r_frame_count;
        n_pos         = r_pos;
        n_s           = r_s;
        n_gain        = r_gain;
        n_fade        = r_fade;
        n_derived_ok  = r_derived_ok;
        n_out         = r_out;
        n_ovalid      = out_acc ? 1'b0 : r_ovalid;
        md_req        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_pos         = i_in.first_frame ? 32'd0 : r_frame_count;
                    n_frame_count = n_pos + 32'd1;
                    n_s           = {sum_adj[16], sum_adj[16:1]};
                end
            end
            ST_GAIN: begin
                md_req.start   = 1'b1;
                md_req.a_mag   = {10'd0, vol_sat};
                md_req.mult    = GAIN_FULL;
                md_req.divisor = PERCENT_FULL;
                n_ret          = ST_FADE;
            end
            ST_FADE: begin
                md_req.start   = 1'b1;
                md_req.a_mag   = {1'b0, cfg.sample_rate};
                md_req.mult    = FADE_MS;
                md_req.divisor = MS_PER_SEC;
                n_ret          = ST_MIX;
            end
            ST_MIX: begin
                md_req.start   = 1'b1;
                md_req.a_mag   = s_mag;
                md_req.a_neg   = s_neg;
                md_req.mult    = {1'b0, r_gain};
                md_req.divisor = GAIN_FULL;
                n_ret          = ST_FIN;
            end
            ST_FIN: begin
                md_req.start   = fin_hit;
                md_req.a_mag   = s_mag;
                md_req.a_neg   = s_neg;
                md_req.mult    = {4'd0, r_pos[11:0]};
                md_req.divisor = {4'd0, r_fade};
                n_ret          = ST_FOUT;
            end
            ST_FOUT: begin
                md_req.start   = fout_hit;
                md_req.a_mag   = s_mag;
                md_req.a_neg   = s_neg;
                md_req.mult    = {4'd0, tail[11:0]};
                md_req.divisor = {4'd0, r_fade};
                n_ret          = ST_EMIT;
            end
            ST_WAIT: begin
                if (md_rsp.done) begin
                    unique case (r_ret)
                        ST_FADE: n_gain = md_rsp.quotient[14:0];
                        ST_MIX: begin
                            n_fade       = (fade_q < FADE_MIN) ? FADE_MIN : fade_q;
                            n_derived_ok = 1'b1;
                        end
                        default: n_s = md_rsp.quotient;
                    endcase
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_out    = clamped;
                    n_ovalid = 1'b1;
                end
            end
            default: begin
                n_ret = r_ret;
            end
        endcase
        if (cfg_wr) begin
            n_derived_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_ret         <= ST_IDLE;
            r_frame_count <= 32'd0;
            r_derived_ok  <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_ret         <= n_ret;
            r_frame_count <= n_frame_count;
            r_derived_ok  <= n_derived_ok;
            r_ovalid      <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_s    <= n_s;
        r_gain <= n_gain;
        r_fade <= n_fade;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("request accepted while a frame is in flight");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_rsp.done |-> (r_state == ST_WAIT))
        else $error("shared unit finished while sequencer not waiting");

    a_fade_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_derived_ok |-> (r_fade >= FADE_MIN))
        else $error("fade length below floor");

    a_first_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.first_frame) |=> (r_frame_count == 32'd1))
        else $error("first frame did not restart the frame count");
`endif

endmodule

`default_nettype wire
